// ===== hdl/scflr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scflr_pkg
// Shared types and constants for the sync, checksum and length framed
// byte receiver.
// ----------------------------------------------------------------------------
package scflr_pkg;

  localparam int HEADER_LEN_DEF  = 5;
  localparam int LEN_HI_POS_DEF  = 3;
  localparam int LEN_LO_POS_DEF  = 4;
  localparam int NUM_BUFFERS_DEF = 4;

  localparam logic [7:0] SYNC_RESET = 8'h01;
  localparam logic [7:0] XOR_INVERT = 8'hFF;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_CHECK,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [1:0]  slot;
    logic [16:0] offset;
    logic [7:0]  data;
    logic        frame_done;
    logic        frame_lost;
    logic        checksum_fail;
  } out_word_t;

endpackage

// ===== hdl/scflr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scflr_core
// Frame state machine: sync hunt, header XOR, checksum check, payload count
// and slot hand-over. Produces one result word per registered input word.
// ----------------------------------------------------------------------------
module scflr_core #(
  parameter int HEADER_LEN  = scflr_pkg::HEADER_LEN_DEF,
  parameter int LEN_HI_POS  = scflr_pkg::LEN_HI_POS_DEF,
  parameter int LEN_LO_POS  = scflr_pkg::LEN_LO_POS_DEF,
  parameter int NUM_BUFFERS = scflr_pkg::NUM_BUFFERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           sync_byte,
  input  logic                 item_en,
  input  scflr_pkg::in_word_t  item,
  output scflr_pkg::out_word_t result
);

  localparam int SLOT_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BUFFERS - 1);
  localparam logic [16:0] HDR_POS = 17'(HEADER_LEN);
  localparam logic [16:0] HI_POS  = 17'(LEN_HI_POS);
  localparam logic [16:0] LO_POS  = 17'(LEN_LO_POS);
  localparam logic [17:0] BASE_LEN = 18'(HEADER_LEN + 1);

  scflr_pkg::phase_t phase, phase_next;
  logic [16:0]       position, position_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [7:0]        length_hi, length_hi_next;
  logic [7:0]        length_lo, length_lo_next;
  logic [SLOT_W-1:0] current_slot, current_slot_next;
  logic              consumer_busy, consumer_busy_next;

  logic [7:0]        b;
  logic [16:0]       pos_inc;
  logic [7:0]        hi_g;
  logic [7:0]        lo_g;
  logic [17:0]       limit;
  logic              wr;
  logic              complete;
  logic              fail;
  logic [SLOT_W+1:0] slot_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= scflr_pkg::PH_HUNT;
      position      <= '0;
      running_xor   <= '0;
      length_hi     <= '0;
      length_lo     <= '0;
      current_slot  <= '0;
      consumer_busy <= 1'b0;
    end else if (item_en) begin
      phase         <= phase_next;
      position      <= position_next;
      running_xor   <= running_xor_next;
      length_hi     <= length_hi_next;
      length_lo     <= length_lo_next;
      current_slot  <= current_slot_next;
      consumer_busy <= consumer_busy_next;
    end
  end

  assign b        = item.rx_byte;
  assign pos_inc  = position + 17'd1;
  assign hi_g     = (position == HI_POS) ? b : length_hi;
  assign lo_g     = (position == LO_POS) ? b : length_lo;
  assign limit    = BASE_LEN + {2'b00, length_hi, length_lo};
  assign slot_ext = {2'b00, current_slot};

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    running_xor_next   = running_xor;
    length_hi_next     = length_hi;
    length_lo_next     = length_lo;
    current_slot_next  = current_slot;
    consumer_busy_next = consumer_busy;
    wr                 = 1'b0;
    complete           = 1'b0;
    fail               = 1'b0;
    result             = '0;

    if (item.func == scflr_pkg::FUNC_RELEASE) begin
      consumer_busy_next = 1'b0;
    end else if (!item.rx_error) begin
      unique case (phase)
        scflr_pkg::PH_HUNT: begin
          if (b == sync_byte) begin
            wr               = 1'b1;
            length_hi_next   = '0;
            length_lo_next   = '0;
            running_xor_next = b;
            position_next    = 17'd1;
            phase_next       = scflr_pkg::PH_HEADER;
          end
        end
        scflr_pkg::PH_HEADER: begin
          wr               = 1'b1;
          length_hi_next   = hi_g;
          length_lo_next   = lo_g;
          running_xor_next = running_xor ^ b;
          position_next    = pos_inc;
          if (pos_inc >= HDR_POS) begin
            phase_next = scflr_pkg::PH_CHECK;
          end
        end
        scflr_pkg::PH_CHECK: begin
          wr             = 1'b1;
          length_hi_next = hi_g;
          length_lo_next = lo_g;
          if ((running_xor ^ scflr_pkg::XOR_INVERT) == b) begin
            position_next    = pos_inc;
            running_xor_next = '0;
            if ({hi_g, lo_g} == 16'd0) begin
              complete = 1'b1;
            end else begin
              phase_next = scflr_pkg::PH_PAYLOAD;
            end
          end else begin
            fail             = 1'b1;
            phase_next       = scflr_pkg::PH_HUNT;
            position_next    = '0;
            running_xor_next = '0;
          end
        end
        default: begin
          wr            = 1'b1;
          position_next = pos_inc;
          if ({1'b0, pos_inc} >= limit) begin
            complete = 1'b1;
          end
        end
      endcase

      if (wr) begin
        result.write_valid   = 1'b1;
        result.slot          = slot_ext[1:0];
        result.offset        = (phase == scflr_pkg::PH_HUNT) ? 17'd0 : position;
        result.data          = b;
        result.checksum_fail = fail;
      end

      if (complete) begin
        phase_next       = scflr_pkg::PH_HUNT;
        position_next    = '0;
        running_xor_next = '0;
        if (!consumer_busy) begin
          consumer_busy_next = 1'b1;
          result.frame_done  = 1'b1;
          current_slot_next  = (current_slot == LAST_SLOT) ? '0
                                                            : current_slot + 1'b1;
        end else begin
          result.frame_lost = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/sync_checksum_length_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_checksum_length_frame_receiver
// Sync-byte hunting, XOR-checked, length-framed byte receiver that reports
// every stored byte as a buffer write with slot and offset.
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   in      | in_valid, in_stall, in_data    | word in
//   out     | out_valid, out_stall, out_data | word out
//   cfg     | cfg_wen, cfg_wdata (sync byte) | write only
//
// One word accepted per cycle while the input is not stalled; each gives one
// result word via the input register, then the result register. Frame state
// updates as a word moves from the input register to the result register.
// Reset is synchronous: both stages empty, hunting for sync, sync byte 0x01.
// A stalled output holds its word; the input stalls only when both stages
// are full and the output is stalled.
// ----------------------------------------------------------------------------
module sync_checksum_length_frame_receiver #(
  parameter int HEADER_LEN  = scflr_pkg::HEADER_LEN_DEF,
  parameter int LEN_HI_POS  = scflr_pkg::LEN_HI_POS_DEF,
  parameter int LEN_LO_POS  = scflr_pkg::LEN_LO_POS_DEF,
  parameter int NUM_BUFFERS = scflr_pkg::NUM_BUFFERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scflr_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scflr_pkg::out_word_t out_data,
  input  logic                 cfg_wen,
  input  logic [7:0]           cfg_wdata
);

  logic                 in_valid_q;
  scflr_pkg::in_word_t  in_q;
  scflr_pkg::out_word_t out_q;
  scflr_pkg::out_word_t result;
  logic [7:0]           sync_byte;
  logic                 advance;

  assign advance  = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && !advance;
  assign out_data = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
      sync_byte  <= scflr_pkg::SYNC_RESET;
    end else begin
      if (!in_stall) begin
        in_valid_q <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        sync_byte <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  scflr_core #(
    .HEADER_LEN  (HEADER_LEN),
    .LEN_HI_POS  (LEN_HI_POS),
    .LEN_LO_POS  (LEN_LO_POS),
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_byte),
    .item_en   (advance),
    .item      (in_q),
    .result    (result)
  );

endmodule

// ===== hdl/scflr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scflr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module scflr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input scflr_pkg::out_word_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |->
      out_data.write_valid && !out_data.frame_lost && !out_data.checksum_fail)
    else $error("frame hand-over without a plain write");

  a_lost: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_lost |->
      out_data.write_valid && !out_data.checksum_fail)
    else $error("lost frame without a write");

  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.checksum_fail |-> out_data.write_valid)
    else $error("checksum failure without the checksum write");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_valid |-> out_data == '0)
    else $error("non-write result carries data");

endmodule

bind sync_checksum_length_frame_receiver scflr_checker u_scflr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
